// ===== src/qte_pkg.sv =====
// ----------------------------------------------------------------------------
// qte_pkg
// Shared constants, lane numbering and the arctangent table for the
// quaternion to Euler angle pipeline.
// ----------------------------------------------------------------------------
package qte_pkg;

   // Angle accumulator: radians times 2^30, with sign and headroom.
   localparam int ZW           = 34;
   localparam int ANGLE_W      = 16;
   localparam int ATAN_ENTRIES = 24;

   // The squared norm is halved until it fits in this many bits.
   localparam int NORM_BITS = 31;
   // Root bits of a product of two values below 2^32 that stays below 2^62.
   localparam int SQRT_BITS = 31;
   localparam int REM_W     = 2 * SQRT_BITS + 2;

   localparam logic signed [ZW-1:0] HALF_PI_Q30     = 34'sd1686629713;
   localparam logic signed [23:0]   DEG_PER_RAD_Q16 = 24'sd3754936;

   localparam int LANES      = 3;
   localparam int LANE_YAW   = 0;
   localparam int LANE_PITCH = 1;
   localparam int LANE_ROLL  = 2;

   // atan(2^-idx) in radians times 2^30, rounded to nearest.
   function automatic logic signed [ZW-1:0] atan_q30(input int idx);
      logic signed [ZW-1:0] v;
      case (idx)
         0:  v = 34'sd843314857;
         1:  v = 34'sd497837829;
         2:  v = 34'sd263043837;
         3:  v = 34'sd133525159;
         4:  v = 34'sd67021687;
         5:  v = 34'sd33543516;
         6:  v = 34'sd16775851;
         7:  v = 34'sd8388437;
         8:  v = 34'sd4194283;
         9:  v = 34'sd2097149;
         10: v = 34'sd1048576;
         11: v = 34'sd524288;
         12: v = 34'sd262144;
         13: v = 34'sd131072;
         14: v = 34'sd65536;
         15: v = 34'sd32768;
         16: v = 34'sd16384;
         17: v = 34'sd8192;
         18: v = 34'sd4096;
         19: v = 34'sd2048;
         20: v = 34'sd1024;
         21: v = 34'sd512;
         22: v = 34'sd256;
         23: v = 34'sd128;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== src/qte_req_if.sv =====
// ----------------------------------------------------------------------------
// qte_req_if
// Request channel: one quaternion per handshake.
// ----------------------------------------------------------------------------
interface qte_req_if #(
   parameter int QUAT_WIDTH = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [QUAT_WIDTH-1:0] quat_real;
   logic signed [QUAT_WIDTH-1:0] quat_i;
   logic signed [QUAT_WIDTH-1:0] quat_j;
   logic signed [QUAT_WIDTH-1:0] quat_k;

   modport source (output valid, quat_real, quat_i, quat_j, quat_k, input ready);
   modport sink   (input valid, quat_real, quat_i, quat_j, quat_k, output ready);
endinterface

// ===== src/qte_rsp_if.sv =====
// ----------------------------------------------------------------------------
// qte_rsp_if
// Response channel: yaw, pitch and roll for one request.
// ----------------------------------------------------------------------------
interface qte_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] yaw_angle;
   logic signed [15:0] pitch_angle;
   logic signed [15:0] roll_angle;
   logic               zero_norm;

   modport source (output valid, yaw_angle, pitch_angle, roll_angle, zero_norm,
                   input ready);
   modport sink   (input valid, yaw_angle, pitch_angle, roll_angle, zero_norm,
                   output ready);
endinterface

// ===== src/qte_prep.sv =====
// ----------------------------------------------------------------------------
// qte_prep
// Two stages: the ten component products, then the atan2 operands, the
// arcsine numerator and the squared norm.
// ----------------------------------------------------------------------------
module qte_prep
   import qte_pkg::*;
#(
   parameter int QW = 16,
   parameter int SW = 2 * QW + 3,
   parameter int DW = 2 * QW + 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic signed [QW-1:0] quat_r,
   input  logic signed [QW-1:0] quat_i,
   input  logic signed [QW-1:0] quat_j,
   input  logic signed [QW-1:0] quat_k,
   output logic                 out_valid,
   output logic signed [SW-1:0] yaw_x,
   output logic signed [SW-1:0] yaw_y,
   output logic signed [SW-1:0] roll_x,
   output logic signed [SW-1:0] roll_y,
   output logic signed [SW-1:0] num,
   output logic        [DW-1:0] den
);
   localparam int PW = 2 * QW;

   logic signed [PW-1:0] rr_ff, ii_ff, jj_ff, kk_ff, jr_ff, ik_ff, ij_ff, kr_ff, jk_ff, ir_ff;
   logic                 v1_ff, v2_ff;
   logic signed [SW-1:0] yaw_x_ff, yaw_y_ff, roll_x_ff, roll_y_ff, num_ff;
   logic        [DW-1:0] den_ff;
   logic signed [SW-1:0] yaw_x_in, yaw_y_in, roll_x_in, roll_y_in, num_in, den_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rr_ff <= PW'(quat_r) * PW'(quat_r);
         ii_ff <= PW'(quat_i) * PW'(quat_i);
         jj_ff <= PW'(quat_j) * PW'(quat_j);
         kk_ff <= PW'(quat_k) * PW'(quat_k);
         jr_ff <= PW'(quat_j) * PW'(quat_r);
         ik_ff <= PW'(quat_i) * PW'(quat_k);
         ij_ff <= PW'(quat_i) * PW'(quat_j);
         kr_ff <= PW'(quat_k) * PW'(quat_r);
         jk_ff <= PW'(quat_j) * PW'(quat_k);
         ir_ff <= PW'(quat_i) * PW'(quat_r);
      end
   end

   always_comb begin
      yaw_x_in  = SW'(ii_ff) - SW'(jj_ff) - SW'(kk_ff) + SW'(rr_ff);
      yaw_y_in  = (SW'(ij_ff) + SW'(kr_ff)) <<< 1;
      roll_x_in = SW'(kk_ff) + SW'(rr_ff) - SW'(ii_ff) - SW'(jj_ff);
      roll_y_in = (SW'(jk_ff) + SW'(ir_ff)) <<< 1;
      num_in    = (SW'(jr_ff) - SW'(ik_ff)) <<< 1;
      den_full  = SW'(rr_ff) + SW'(ii_ff) + SW'(jj_ff) + SW'(kk_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         yaw_x_ff  <= yaw_x_in;
         yaw_y_ff  <= yaw_y_in;
         roll_x_ff <= roll_x_in;
         roll_y_ff <= roll_y_in;
         num_ff    <= num_in;
         den_ff    <= den_full[DW-1:0];
      end
   end

   assign out_valid = v2_ff;
   assign yaw_x     = yaw_x_ff;
   assign yaw_y     = yaw_y_ff;
   assign roll_x    = roll_x_ff;
   assign roll_y    = roll_y_ff;
   assign num       = num_ff;
   assign den       = den_ff;
endmodule

// ===== src/qte_root.sv =====
// ----------------------------------------------------------------------------
// qte_root
// Arcsine leg: clamps the numerator, scales both operands into range,
// forms (d - a)(d + a) and takes its floor square root one bit per stage.
// ----------------------------------------------------------------------------
module qte_root
   import qte_pkg::*;
#(
   parameter int SW     = 35,
   parameter int DW     = 33,
   parameter int PASS_W = 140
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic signed [SW-1:0]     num,
   input  logic        [DW-1:0]     den,
   input  logic        [PASS_W-1:0] in_pass,
   output logic                     out_valid,
   output logic [SQRT_BITS-1:0]     root,
   output logic [NORM_BITS-1:0]     mag,
   output logic                     neg,
   output logic                     zero,
   output logic        [PASS_W-1:0] out_pass
);
   localparam int SHW = $clog2(DW + 1);
   localparam int LW  = (DW > NORM_BITS) ? DW : NORM_BITS;

   // Stage one: clamp and shift count.
   logic [SW-1:0]  absn;
   logic [DW-1:0]  magc;
   logic [SHW-1:0] sh;
   logic           v1_ff, neg1_ff, zero1_ff;
   logic [DW-1:0]  den1_ff, mag1_ff;
   logic [SHW-1:0] sh1_ff;
   logic [PASS_W-1:0] pass1_ff;

   always_comb begin
      absn = num[SW-1] ? SW'(-num) : SW'(num);
      magc = (absn > SW'(den)) ? den : absn[DW-1:0];
      sh   = '0;
      for (int b = NORM_BITS; b < DW; b++) begin
         if (den[b]) sh = SHW'(b - NORM_BITS + 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (en) v1_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den1_ff  <= den;
         mag1_ff  <= magc;
         sh1_ff   <= sh;
         neg1_ff  <= num[SW-1];
         zero1_ff <= (den == '0);
         pass1_ff <= in_pass;
      end
   end

   // Stage two: scale and form the two factors.
   logic [LW-1:0]        dn_w, mn_w;
   logic [NORM_BITS:0]   diff_in, sum_in;
   logic                 v2_ff, neg2_ff, zero2_ff;
   logic [NORM_BITS:0]   diff2_ff, sum2_ff;
   logic [NORM_BITS-1:0] mag2_ff;
   logic [PASS_W-1:0]    pass2_ff;

   always_comb begin
      dn_w    = LW'(den1_ff) >> sh1_ff;
      mn_w    = LW'(mag1_ff) >> sh1_ff;
      diff_in = {1'b0, dn_w[NORM_BITS-1:0]} - {1'b0, mn_w[NORM_BITS-1:0]};
      sum_in  = {1'b0, dn_w[NORM_BITS-1:0]} + {1'b0, mn_w[NORM_BITS-1:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (en) v2_ff <= v1_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         diff2_ff <= diff_in;
         sum2_ff  <= sum_in;
         mag2_ff  <= mn_w[NORM_BITS-1:0];
         neg2_ff  <= neg1_ff;
         zero2_ff <= zero1_ff;
         pass2_ff <= pass1_ff;
      end
   end

   // Stage three feeds the root chain; index 0 is the product register.
   logic                 vq_ff   [SQRT_BITS+1];
   logic [REM_W-1:0]     rem_ff  [SQRT_BITS+1];
   logic [SQRT_BITS-1:0] rt_ff   [SQRT_BITS+1];
   logic [NORM_BITS-1:0] magq_ff [SQRT_BITS+1];
   logic                 negq_ff [SQRT_BITS+1];
   logic                 zeroq_ff[SQRT_BITS+1];
   logic [PASS_W-1:0]    passq_ff[SQRT_BITS+1];

   always_ff @(posedge clock) begin
      if (reset) vq_ff[0] <= 1'b0;
      else if (en) vq_ff[0] <= v2_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]   <= REM_W'(diff2_ff) * REM_W'(sum2_ff);
         rt_ff[0]    <= '0;
         magq_ff[0]  <= mag2_ff;
         negq_ff[0]  <= neg2_ff;
         zeroq_ff[0] <= zero2_ff;
         passq_ff[0] <= pass2_ff;
      end
   end

   for (genvar g = 0; g < SQRT_BITS; g++) begin : g_sqrt
      localparam int P = SQRT_BITS - 1 - g;
      logic [REM_W-1:0] trial;
      logic             take;

      // The root so far has no bits at or below P, so OR acts as add.
      assign trial = (REM_W'(rt_ff[g]) << (P + 1)) | (REM_W'(1) << (2 * P));
      assign take  = (rem_ff[g] >= trial);

      always_ff @(posedge clock) begin
         if (reset) vq_ff[g+1] <= 1'b0;
         else if (en) vq_ff[g+1] <= vq_ff[g];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g+1]   <= take ? rem_ff[g] - trial : rem_ff[g];
            rt_ff[g+1]    <= take ? (rt_ff[g] | (SQRT_BITS'(1) << P)) : rt_ff[g];
            magq_ff[g+1]  <= magq_ff[g];
            negq_ff[g+1]  <= negq_ff[g];
            zeroq_ff[g+1] <= zeroq_ff[g];
            passq_ff[g+1] <= passq_ff[g];
         end
      end
   end

   assign out_valid = vq_ff[SQRT_BITS];
   assign root      = rt_ff[SQRT_BITS];
   assign mag       = magq_ff[SQRT_BITS];
   assign neg       = negq_ff[SQRT_BITS];
   assign zero      = zeroq_ff[SQRT_BITS];
   assign out_pass  = passq_ff[SQRT_BITS];
endmodule

// ===== src/qte_cordic.sv =====
// ----------------------------------------------------------------------------
// qte_cordic
// Pipelined vectoring CORDIC, one iteration per stage, for three lanes
// that share a valid bit.
// ----------------------------------------------------------------------------
module qte_cordic
   import qte_pkg::*;
#(
   parameter int STAGES = 16,
   parameter int CW     = 37
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic                 in_tag,
   input  logic signed [CW-1:0] in_x [LANES],
   input  logic signed [CW-1:0] in_y [LANES],
   output logic                 out_valid,
   output logic                 out_tag,
   output logic signed [ZW-1:0] out_z[LANES]
);
   logic                 v_ff   [STAGES+1];
   logic                 tag_ff [STAGES+1];
   logic signed [CW-1:0] x_ff   [STAGES+1][LANES];
   logic signed [CW-1:0] y_ff   [STAGES+1][LANES];
   logic signed [ZW-1:0] z_ff   [STAGES+1][LANES];
   logic                 nul_ff [STAGES+1][LANES];

   // Entry stage: a vector in the left half plane is turned by a quarter turn.
   always_ff @(posedge clock) begin
      if (reset) v_ff[0] <= 1'b0;
      else if (en) v_ff[0] <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff[0] <= in_tag;
         for (int l = 0; l < LANES; l++) begin
            nul_ff[0][l] <= (in_x[l] == '0) && (in_y[l] == '0);
            if (!in_x[l][CW-1]) begin
               x_ff[0][l] <= in_x[l];
               y_ff[0][l] <= in_y[l];
               z_ff[0][l] <= '0;
            end else if (!in_y[l][CW-1]) begin
               x_ff[0][l] <= in_y[l];
               y_ff[0][l] <= -in_x[l];
               z_ff[0][l] <= HALF_PI_Q30;
            end else begin
               x_ff[0][l] <= -in_y[l];
               y_ff[0][l] <= in_x[l];
               z_ff[0][l] <= -HALF_PI_Q30;
            end
         end
      end
   end

   for (genvar g = 0; g < STAGES; g++) begin : g_iter
      localparam logic signed [ZW-1:0] ANG = atan_q30(g);

      always_ff @(posedge clock) begin
         if (reset) v_ff[g+1] <= 1'b0;
         else if (en) v_ff[g+1] <= v_ff[g];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            tag_ff[g+1] <= tag_ff[g];
            for (int l = 0; l < LANES; l++) begin
               nul_ff[g+1][l] <= nul_ff[g][l];
               if (!y_ff[g][l][CW-1]) begin
                  x_ff[g+1][l] <= x_ff[g][l] + (y_ff[g][l] >>> g);
                  y_ff[g+1][l] <= y_ff[g][l] - (x_ff[g][l] >>> g);
                  z_ff[g+1][l] <= z_ff[g][l] + ANG;
               end else begin
                  x_ff[g+1][l] <= x_ff[g][l] - (y_ff[g][l] >>> g);
                  y_ff[g+1][l] <= y_ff[g][l] + (x_ff[g][l] >>> g);
                  z_ff[g+1][l] <= z_ff[g][l] - ANG;
               end
            end
         end
      end
   end

   assign out_valid = v_ff[STAGES];
   assign out_tag   = tag_ff[STAGES];

   // The zero vector has angle zero.
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         out_z[l] = nul_ff[STAGES][l] ? '0 : z_ff[STAGES][l];
      end
   end
endmodule

// ===== src/qte_scale.sv =====
// ----------------------------------------------------------------------------
// qte_scale
// Converts the radian accumulators to output units with rounding and
// saturation; two stages, the second one is the response register.
// ----------------------------------------------------------------------------
module qte_scale
   import qte_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic                      in_tag,
   input  logic                      degree_mode,
   input  logic signed [ZW-1:0]      in_z [LANES],
   output logic                      out_valid,
   output logic                      out_tag,
   output logic signed [ANGLE_W-1:0] angle[LANES]
);
   localparam int PW = ZW + 24;
   localparam logic signed [PW-1:0] MAX_V = PW'(32767);
   localparam logic signed [PW-1:0] MIN_V = -PW'(32768);

   logic                 v1_ff, v2_ff, tag1_ff, tag2_ff, mode1_ff;
   logic signed [PW-1:0] prod_ff[LANES];
   logic signed [ZW-1:0] z1_ff  [LANES];
   logic signed [PW-1:0] val    [LANES];
   logic signed [ANGLE_W-1:0] angle_ff[LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag1_ff  <= in_tag;
         mode1_ff <= degree_mode;
         for (int l = 0; l < LANES; l++) begin
            prod_ff[l] <= PW'(in_z[l]) * PW'(DEG_PER_RAD_Q16);
            z1_ff[l]   <= in_z[l];
         end
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         if (mode1_ff) val[l] = (prod_ff[l] + (PW'(1) <<< 38)) >>> 39;
         else          val[l] = (PW'(z1_ff[l]) + (PW'(1) <<< 16)) >>> 17;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag2_ff <= tag1_ff;
         for (int l = 0; l < LANES; l++) begin
            if (val[l] > MAX_V)      angle_ff[l] <= MAX_V[ANGLE_W-1:0];
            else if (val[l] < MIN_V) angle_ff[l] <= MIN_V[ANGLE_W-1:0];
            else                     angle_ff[l] <= val[l][ANGLE_W-1:0];
         end
      end
   end

   assign out_valid = v2_ff;
   assign out_tag   = tag2_ff;
   assign angle     = angle_ff;
endmodule

// ===== src/quaternion_to_euler_core.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_euler_core
// ZYX Euler angles (yaw, pitch, roll) from an orientation quaternion.
// ----------------------------------------------------------------------------
// The core takes one quaternion request per clock and returns yaw, pitch and
// roll in the same order, as long as the response side keeps taking results.
// The latency is set by the 31-stage square root of the pitch leg, which runs
// while the yaw and roll operands wait beside it, followed by one shared
// three-lane CORDIC pipeline. A stall on the response channel freezes the
// whole pipeline, so nothing is lost or repeated, and request ready simply
// follows the response side. Angles come out in degrees times 128 when
// degree_mode is set (the reset value) and in radians times 8192 otherwise;
// write the mode only while no request is in flight. A quaternion of zero
// norm gives zero angles and sets zero_norm.
// ----------------------------------------------------------------------------
module quaternion_to_euler_core
   import qte_pkg::*;
#(
   parameter int CORDIC_STAGES = 16,
   parameter int QUAT_WIDTH    = 16
) (
   input  logic clock,
   input  logic reset,
   qte_req_if.sink   req_chan,
   qte_rsp_if.source rsp_chan,
   input  logic csr_wr_en,
   input  logic csr_wr_data
);
   localparam int SW     = 2 * QUAT_WIDTH + 3;
   localparam int DW     = 2 * QUAT_WIDTH + 1;
   localparam int PASS_W = 4 * SW;
   localparam int CW     = (2 * QUAT_WIDTH + 5 > 35) ? 2 * QUAT_WIDTH + 5 : 35;
   localparam int TOTAL_LAT = 2 + (3 + SQRT_BITS) + (CORDIC_STAGES + 1) + 2;
   localparam int OCC_W     = $clog2(TOTAL_LAT + 1) + 1;

   // Mode register.
   logic degree_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) degree_mode_ff <= 1'b1;
      else if (csr_wr_en) degree_mode_ff <= csr_wr_data;
   end

   // The whole pipeline moves whenever the response register is free or being taken.
   logic rsp_valid;
   logic en;

   assign en             = !rsp_valid || rsp_chan.ready;
   assign req_chan.ready = en;

   // Products, sums and squared norm.
   logic                 prep_valid;
   logic signed [SW-1:0] yaw_x, yaw_y, roll_x, roll_y, num;
   logic        [DW-1:0] den;

   qte_prep #(.QW(QUAT_WIDTH), .SW(SW), .DW(DW)) u_prep (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_chan.valid),
      .quat_r    (req_chan.quat_real),
      .quat_i    (req_chan.quat_i),
      .quat_j    (req_chan.quat_j),
      .quat_k    (req_chan.quat_k),
      .out_valid (prep_valid),
      .yaw_x     (yaw_x),
      .yaw_y     (yaw_y),
      .roll_x    (roll_x),
      .roll_y    (roll_y),
      .num       (num),
      .den       (den)
   );

   // Pitch leg; the yaw and roll operands ride along to stay aligned.
   logic                 root_valid, pitch_neg, pitch_zero;
   logic [SQRT_BITS-1:0] pitch_root;
   logic [NORM_BITS-1:0] pitch_mag;
   logic [PASS_W-1:0]    pass_out;

   qte_root #(.SW(SW), .DW(DW), .PASS_W(PASS_W)) u_root (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (prep_valid),
      .num       (num),
      .den       (den),
      .in_pass   ({yaw_x, yaw_y, roll_x, roll_y}),
      .out_valid (root_valid),
      .root      (pitch_root),
      .mag       (pitch_mag),
      .neg       (pitch_neg),
      .zero      (pitch_zero),
      .out_pass  (pass_out)
   );

   // Lane operands for the CORDIC; pitch is atan2(+-a, root).
   logic signed [CW-1:0] cx[LANES];
   logic signed [CW-1:0] cy[LANES];
   logic signed [SW-1:0] yx_d, yy_d, rx_d, ry_d;

   always_comb begin
      {yx_d, yy_d, rx_d, ry_d} = pass_out;
      cx[LANE_YAW]   = CW'(yx_d);
      cy[LANE_YAW]   = CW'(yy_d);
      cx[LANE_ROLL]  = CW'(rx_d);
      cy[LANE_ROLL]  = CW'(ry_d);
      cx[LANE_PITCH] = CW'({1'b0, pitch_root});
      cy[LANE_PITCH] = pitch_neg ? -CW'({1'b0, pitch_mag}) : CW'({1'b0, pitch_mag});
   end

   logic                 cordic_valid, cordic_zero;
   logic signed [ZW-1:0] cz[LANES];

   qte_cordic #(.STAGES(CORDIC_STAGES), .CW(CW)) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (root_valid),
      .in_tag    (pitch_zero),
      .in_x      (cx),
      .in_y      (cy),
      .out_valid (cordic_valid),
      .out_tag   (cordic_zero),
      .out_z     (cz)
   );

   // Unit conversion; its last stage is the response register.
   logic                      zero_out;
   logic signed [ANGLE_W-1:0] angle[LANES];

   qte_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (cordic_valid),
      .in_tag      (cordic_zero),
      .degree_mode (degree_mode_ff),
      .in_z        (cz),
      .out_valid   (rsp_valid),
      .out_tag     (zero_out),
      .angle       (angle)
   );

   assign rsp_chan.valid       = rsp_valid;
   assign rsp_chan.yaw_angle   = angle[LANE_YAW];
   assign rsp_chan.roll_angle  = angle[LANE_ROLL];
   assign rsp_chan.pitch_angle = zero_out ? '0 : angle[LANE_PITCH];
   assign rsp_chan.zero_norm   = zero_out;

   // Requests in flight, kept for checking the pipeline bookkeeping.
   logic [OCC_W-1:0] occ_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_ff + OCC_W'(req_chan.valid && en) - OCC_W'(rsp_valid && rsp_chan.ready);
      end
   end

   // The pipeline never holds more requests than it has stages.
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(TOTAL_LAT))
      else $error("more requests in flight than pipeline stages");

   // A response is only shown for a request that was taken.
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (occ_ff != '0))
      else $error("response without an outstanding request");

   // After reset the response register is empty.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A stalled response keeps the in-flight count unchanged; request ready is low then, so none enters.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_chan.ready) |=> (occ_ff == $past(occ_ff)))
      else $error("in-flight count changed during a stall");
endmodule
